[hdl/sesc_pkg.sv]
// Package with the shared types, character codes and constants of the string decoder.
`timescale 1ns / 1ps

package sesc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_UPPER_U   = 8'h55;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NEWLINE = 2'd1;
  localparam logic [1:0] ERR_HEX     = 2'd2;

  localparam logic [3:0] DIGITS_SHORT = 4'd4;
  localparam logic [3:0] DIGITS_LONG  = 4'd8;

  localparam logic [31:0] LIMIT_1BYTE = 32'h80;
  localparam logic [31:0] LIMIT_2BYTE = 32'h800;
  localparam logic [31:0] LIMIT_3BYTE = 32'h10000;
  localparam logic [7:0]  LEAD_2BYTE  = 8'hC0;
  localparam logic [7:0]  LEAD_3BYTE  = 8'hE0;
  localparam logic [7:0]  LEAD_4BYTE  = 8'hF0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;
  localparam logic [5:0]  CONT_MASK   = 6'h3F;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_HEX    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       escapes_on;
    logic       multiline;
    logic       first_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] error;
  } out_word_t;

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
    logic [1:0]      error;
  } cmd_t;

endpackage

[hdl/sesc_front.sv]
// Front end: accepts input words, tracks escape state and builds output commands.
`timescale 1ns / 1ps

module sesc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sesc_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               push,
  output sesc_pkg::cmd_t     push_cmd
);

  sesc_pkg::phase_t phase_r, phase_nxt, phase_cur;
  logic [3:0]  digits_r, digits_nxt, digits_cur;
  logic [31:0] code_r, code_nxt, code_cur;
  logic        emitted_r, emitted_nxt, emitted_cur;
  logic        errseen_r, errseen_nxt, errseen_cur;

  logic        in_fire;
  logic        has_result;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [31:0] code_shift;
  logic [3:0]  digits_dec;
  logic [7:0]  b;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && has_result;
  assign b        = in_data.in_byte;

  always_comb begin
    phase_cur   = in_data.first_of_string ? sesc_pkg::PH_NORMAL : phase_r;
    digits_cur  = in_data.first_of_string ? 4'd0 : digits_r;
    code_cur    = in_data.first_of_string ? 32'd0 : code_r;
    emitted_cur = in_data.first_of_string ? 1'b0 : emitted_r;
    errseen_cur = in_data.first_of_string ? 1'b0 : errseen_r;
  end

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_d = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_d = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_d = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code_shift = {code_cur[27:0], hex_d};
  assign digits_dec = digits_cur - 4'd1;

  always_comb begin
    phase_nxt   = phase_cur;
    digits_nxt  = digits_cur;
    code_nxt    = code_cur;
    errseen_nxt = errseen_cur;
    emitted_nxt = emitted_cur | (has_result && push_cmd.error == sesc_pkg::ERR_NONE);
    if (!errseen_cur) begin
      unique case (phase_cur)
        sesc_pkg::PH_ESCAPE: begin
          phase_nxt = sesc_pkg::PH_NORMAL;
          if (b == sesc_pkg::CH_LOWER_U || b == sesc_pkg::CH_UPPER_U) begin
            phase_nxt  = sesc_pkg::PH_HEX;
            digits_nxt = (b == sesc_pkg::CH_LOWER_U) ? sesc_pkg::DIGITS_SHORT
                                                     : sesc_pkg::DIGITS_LONG;
            code_nxt   = 32'd0;
          end
        end
        sesc_pkg::PH_HEX: begin
          if (!hex_ok) begin
            phase_nxt   = sesc_pkg::PH_NORMAL;
            digits_nxt  = 4'd0;
            code_nxt    = 32'd0;
            errseen_nxt = 1'b1;
          end else begin
            code_nxt   = code_shift;
            digits_nxt = digits_dec;
            if (digits_dec == 4'd0) begin
              phase_nxt = sesc_pkg::PH_NORMAL;
            end
          end
        end
        default: begin
          phase_nxt = sesc_pkg::PH_NORMAL;
          if (b == sesc_pkg::CH_NEWLINE) begin
            if (!in_data.multiline) begin
              digits_nxt  = 4'd0;
              code_nxt    = 32'd0;
              errseen_nxt = 1'b1;
            end
          end else if (in_data.escapes_on && b == sesc_pkg::CH_BACKSLASH) begin
            phase_nxt = sesc_pkg::PH_ESCAPE;
          end
        end
      endcase
    end
  end

  always_comb begin
    has_result        = 1'b0;
    push_cmd.last_idx = 2'd0;
    push_cmd.bytes    = '0;
    push_cmd.error    = sesc_pkg::ERR_NONE;
    if (!errseen_cur) begin
      unique case (phase_cur)
        sesc_pkg::PH_ESCAPE: begin
          if (b != sesc_pkg::CH_LOWER_U && b != sesc_pkg::CH_UPPER_U) begin
            has_result        = 1'b1;
            push_cmd.bytes[0] = (b == sesc_pkg::CH_LOWER_N) ? sesc_pkg::CH_NEWLINE : b;
          end
        end
        sesc_pkg::PH_HEX: begin
          if (!hex_ok) begin
            has_result     = 1'b1;
            push_cmd.error = sesc_pkg::ERR_HEX;
          end else if (digits_dec == 4'd0) begin
            has_result = 1'b1;
            if (code_shift < sesc_pkg::LIMIT_1BYTE) begin
              push_cmd.bytes[0] = code_shift[7:0];
            end else if (code_shift < sesc_pkg::LIMIT_2BYTE) begin
              push_cmd.last_idx = 2'd1;
              push_cmd.bytes[0] = code_shift[13:6] | sesc_pkg::LEAD_2BYTE;
              push_cmd.bytes[1] = {2'b00, code_shift[5:0] & sesc_pkg::CONT_MASK}
                                  | sesc_pkg::CONT_MARK;
            end else if (code_shift < sesc_pkg::LIMIT_3BYTE) begin
              push_cmd.last_idx = 2'd2;
              push_cmd.bytes[0] = code_shift[19:12] | sesc_pkg::LEAD_3BYTE;
              push_cmd.bytes[1] = {2'b00, code_shift[11:6]} | sesc_pkg::CONT_MARK;
              push_cmd.bytes[2] = {2'b00, code_shift[5:0]} | sesc_pkg::CONT_MARK;
            end else begin
              push_cmd.last_idx = 2'd3;
              push_cmd.bytes[0] = code_shift[25:18] | sesc_pkg::LEAD_4BYTE;
              push_cmd.bytes[1] = {2'b00, code_shift[17:12]} | sesc_pkg::CONT_MARK;
              push_cmd.bytes[2] = {2'b00, code_shift[11:6]} | sesc_pkg::CONT_MARK;
              push_cmd.bytes[3] = {2'b00, code_shift[5:0]} | sesc_pkg::CONT_MARK;
            end
          end
        end
        default: begin
          if (b == sesc_pkg::CH_NEWLINE) begin
            if (!in_data.multiline) begin
              has_result     = 1'b1;
              push_cmd.error = sesc_pkg::ERR_NEWLINE;
            end else if (emitted_cur) begin
              has_result        = 1'b1;
              push_cmd.bytes[0] = b;
            end
          end else if (!(in_data.escapes_on && b == sesc_pkg::CH_BACKSLASH)) begin
            has_result        = 1'b1;
            push_cmd.bytes[0] = b;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sesc_pkg::PH_NORMAL;
      digits_r  <= 4'd0;
      code_r    <= 32'd0;
      emitted_r <= 1'b0;
      errseen_r <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      digits_r  <= digits_nxt;
      code_r    <= code_nxt;
      emitted_r <= emitted_nxt;
      errseen_r <= errseen_nxt;
    end
  end

endmodule

[hdl/sesc_queue.sv]
// Command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module sesc_queue #(
  parameter int DEPTH = sesc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sesc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sesc_pkg::cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sesc_pkg::cmd_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hdl/sesc_back.sv]
// Back end: sends each queued command out one word at a time through an output register.
`timescale 1ns / 1ps

module sesc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  sesc_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sesc_pkg::out_word_t out_data
);

  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  sesc_pkg::out_word_t out_word_r, out_word_nxt;
  logic                load;
  logic                at_last;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign at_last   = (idx_r == head_cmd.last_idx);
  assign pop       = load && at_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_word_nxt.out_byte = head_cmd.bytes[idx_r];
      out_word_nxt.last     = at_last;
      out_word_nxt.error    = head_cmd.error;
      idx_nxt               = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/string_escape_utf8_decoder_core.sv]
// Top level of the string unescaper with UTF-8 encoding of hex escapes.
//
//   Channel  Ports                         Moves
//   input    in_valid, in_ready, in_data   one body byte with string flags per word
//   output   out_valid, out_ready, out_data one decoded byte, last flag, error code
//
// The front end takes one input word per cycle while the command queue has room.
// Each word makes zero or one queue command; the back end sends one output word per
// cycle while out_ready allows, and pops a command once its last byte is loaded.
// First output passes through the queue entry and then the output register.
// rst_n is synchronous and clears the escape state, the queue and out_valid.
// Stalls on out_ready fill the queue, and in_ready drops once it is full.
`timescale 1ns / 1ps

module string_escape_utf8_decoder_core #(
  parameter int QUEUE_DEPTH = sesc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sesc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sesc_pkg::out_word_t out_data
);

  logic           q_full;
  logic           push;
  sesc_pkg::cmd_t push_cmd;
  logic           pop;
  logic           head_valid;
  sesc_pkg::cmd_t head_cmd;

  sesc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sesc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
